### hw/rtl/lsf_pkg.sv
// Shared constants, types and codes of the Laplacian sharpen filter.
package lsf_pkg;

  localparam int unsigned MaxWidth   = 1024;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned ColW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned WidthRegW  = 11;
  localparam int unsigned HeightRegW = 13;
  localparam int unsigned CfgIdxW    = 8;
  localparam int unsigned CfgDataW   = 13;
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned PixW       = NumChan * ChanW;
  localparam int unsigned LineW      = 2 * PixW;
  localparam int unsigned NsumW      = ChanW + 3;
  localparam int unsigned DiffW      = NsumW + 1;
  localparam int unsigned QDepth     = 4;
  localparam int unsigned QPtrW      = $clog2(QDepth);
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = CfgIdxW'(1);

  localparam logic [WidthRegW-1:0]  FrameWidthReset  = WidthRegW'(1024);
  localparam logic [HeightRegW-1:0] FrameHeightReset = HeightRegW'(768);

  // centre sample and sum of its eight neighbours for one channel
  typedef struct packed {
    logic [ChanW-1:0] centre;
    logic [NsumW-1:0] nsum;
  } chan_work_t;

  typedef struct packed {
    chan_work_t [NumChan-1:0] chan;
    logic [ColW-1:0]          col;
    logic [RowW-1:0]          row;
    logic                     frame_end;
  } work_t;

  typedef struct packed {
    logic [NumChan-1:0][ChanW-1:0] rgb;
    logic [ColW-1:0]               col;
    logic [RowW-1:0]               row;
    logic                          frame_end;
  } result_t;

  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } q_stat_t;

endpackage

### hw/rtl/lsf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lsf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/lsf_fifo.sv
// Short queue of window work between the front and back parts.
module lsf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lsf_pkg::work_t   data_i,
  input  logic             pop_i,
  output lsf_pkg::work_t   data_o,
  output lsf_pkg::q_stat_t stat_o
);
  import lsf_pkg::*;

  work_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && (cnt_q != QCntW'(QDepth));
  assign do_pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

### hw/rtl/lsf_front.sv
// Front part: size registers, raster counters, line store, 3x3 window, neighbour sums.
module lsf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [lsf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [lsf_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                            accept_i,
  input  logic [lsf_pkg::PixW-1:0]        pixel_i,
  input  lsf_pkg::q_stat_t                q_stat_i,
  output logic                            full_o,
  output logic                            q_push_o,
  output lsf_pkg::work_t                  q_data_o
);
  import lsf_pkg::*;

  logic [WidthRegW-1:0]  frame_width_q;
  logic [HeightRegW-1:0] frame_height_q;
  logic [WidthRegW-1:0]  w_eff;
  logic [HeightRegW-1:0] h_eff;

  logic [ColW-1:0] col_q, col_d, c;
  logic [RowW-1:0] row_q, row_d, r;
  logic            col_last, row_last;

  // stage B: line store data comes back this cycle
  logic            b_valid_q;
  logic            b_interior_q;
  logic [ColW-1:0] b_addr_q;
  logic [PixW-1:0] b_px_q;
  logic [ColW-1:0] b_col_q;
  logic [RowW-1:0] b_row_q;
  logic            b_fe_q;

  logic [LineW-1:0]          line_rdata;
  logic [5:0][PixW-1:0]      win_q;
  logic [2:0][PixW-1:0]      cur;
  logic [QCntW:0]            pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i[WidthRegW-1:0];
        CfgFrameHeight: frame_height_q <= cfg_data_i[HeightRegW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (frame_width_q < WidthRegW'(3)) begin
      w_eff = WidthRegW'(3);
    end else if (frame_width_q > WidthRegW'(MaxWidth)) begin
      w_eff = WidthRegW'(MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
    priority if (frame_height_q < HeightRegW'(3)) begin
      h_eff = HeightRegW'(3);
    end else if (frame_height_q > HeightRegW'(MaxHeight)) begin
      h_eff = HeightRegW'(MaxHeight);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // wrap a counter that a smaller size has left out of range
  assign c = ({1'b0, col_q} < w_eff) ? col_q : '0;
  assign r = ({1'b0, row_q} < h_eff) ? row_q : '0;

  assign col_last = ({1'b0, c} + WidthRegW'(1)) >= w_eff;
  assign row_last = ({1'b0, r} + HeightRegW'(1)) >= h_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : r + RowW'(1);
      end else begin
        col_d = c + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      b_valid_q    <= 1'b0;
      b_interior_q <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      b_valid_q    <= accept_i;
      b_interior_q <= accept_i && (c >= ColW'(2)) && (r >= RowW'(2));
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      b_addr_q <= c;
      b_px_q   <= pixel_i;
      b_col_q  <= c - ColW'(1);
      b_row_q  <= r - RowW'(1);
      b_fe_q   <= ({1'b0, c} == w_eff - WidthRegW'(1)) &&
                  ({1'b0, r} == h_eff - HeightRegW'(1));
    end
  end

  // each entry holds row r-2 in the low half and row r-1 in the high half
  lsf_ram #(
    .Width (LineW),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (b_valid_q),
    .waddr_i (b_addr_q),
    .wdata_i ({b_px_q, line_rdata[LineW-1:PixW]}),
    .re_i    (accept_i),
    .raddr_i (c),
    .rdata_o (line_rdata)
  );

  assign cur[0] = line_rdata[PixW-1:0];
  assign cur[1] = line_rdata[LineW-1:PixW];
  assign cur[2] = b_px_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (b_valid_q) begin
      win_q[2:0] <= win_q[5:3];
      win_q[5:3] <= cur;
    end
  end

  always_comb begin
    q_data_o.col       = b_col_q;
    q_data_o.row       = b_row_q;
    q_data_o.frame_end = b_fe_q;
    for (int k = 0; k < NumChan; k++) begin
      q_data_o.chan[k].centre = win_q[4][k*ChanW +: ChanW];
      q_data_o.chan[k].nsum   =
          (NsumW'(win_q[0][k*ChanW +: ChanW]) + NsumW'(win_q[1][k*ChanW +: ChanW])) +
          (NsumW'(win_q[2][k*ChanW +: ChanW]) + NsumW'(win_q[3][k*ChanW +: ChanW])) +
          (NsumW'(win_q[5][k*ChanW +: ChanW]) + NsumW'(cur[0][k*ChanW +: ChanW])) +
          (NsumW'(cur[1][k*ChanW +: ChanW]) + NsumW'(cur[2][k*ChanW +: ChanW]));
    end
  end

  assign q_push_o = b_valid_q && b_interior_q;

  // reserve queue room for the request still in stage B
  assign pending = {1'b0, q_stat_i.count} + (QCntW + 1)'(q_push_o);
  assign full_o  = pending >= (QCntW + 1)'(QDepth);

endmodule

### hw/rtl/lsf_back.sv
// Back part: Laplacian result per channel, clamp, and the output register.
module lsf_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsf_pkg::work_t   q_data_i,
  input  lsf_pkg::q_stat_t q_stat_i,
  output logic             q_pop_o,
  input  logic             pop_i,
  output logic             empty_o,
  output lsf_pkg::result_t result_o
);
  import lsf_pkg::*;

  logic    out_valid_q, out_valid_d;
  result_t out_q, res;
  logic signed [DiffW-1:0] diff [NumChan];

  assign q_pop_o = !q_stat_i.empty && (!out_valid_q || pop_i);

  always_comb begin
    res.col       = q_data_i.col;
    res.row       = q_data_i.row;
    res.frame_end = q_data_i.frame_end;
    for (int k = 0; k < NumChan; k++) begin
      diff[k] = $signed({1'b0, q_data_i.chan[k].centre, 3'b000}) -
                $signed({1'b0, q_data_i.chan[k].nsum});
      priority if (diff[k][DiffW-1]) begin
        res.rgb[k] = '0;
      end else if (diff[k][DiffW-2:ChanW] != '0) begin
        res.rgb[k] = '1;
      end else begin
        res.rgb[k] = diff[k][ChanW-1:0];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= res;
    end
  end

  assign empty_o  = !out_valid_q;
  assign result_o = out_q;

endmodule

### hw/rtl/laplacian_3x3_sharpen_filter_unit.sv
// Top level of the 3x3 Laplacian sharpen filter over a raster RGB pixel stream.
//
// Pixels enter row by row, left to right, through push/full: a pixel is taken
// at a clock edge with push high and full low. Frame size comes from the
// configuration channel (index 0: width, index 1: height), written while idle
// by the user (not enforced). For every interior pixel the block gives
// 8*centre minus its eight neighbours per channel, clamped to 0..255, with
// its column, row and a mark on the last interior pixel of the frame. Border
// pixels give no result. A result, begun by the pixel below and right of its
// centre, passes stage B and the queue into the output register (empty low)
// and leaves on pop. One pixel a cycle is sustained while full is low; the
// line store is one RAM read and one write per pixel, so no pixel waits on
// another. When pop stalls, results gather in a four-entry queue and the
// output register; full rises once that room is spoken for.
// Reset clears counters, window and queue and loads width 1024, height 768;
// the line store is not cleared, and the first two rows fill it.
module laplacian_3x3_sharpen_filter_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [lsf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lsf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         push,
  output logic                         full,
  input  logic [lsf_pkg::ChanW-1:0]    red_in_i,
  input  logic [lsf_pkg::ChanW-1:0]    green_in_i,
  input  logic [lsf_pkg::ChanW-1:0]    blue_in_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [lsf_pkg::ChanW-1:0]    red_out_o,
  output logic [lsf_pkg::ChanW-1:0]    green_out_o,
  output logic [lsf_pkg::ChanW-1:0]    blue_out_o,
  output logic [lsf_pkg::ColW-1:0]     out_col_o,
  output logic [lsf_pkg::RowW-1:0]     out_row_o,
  output logic                         frame_end_o
);
  import lsf_pkg::*;

  logic    accept;
  logic    q_push, q_pop;
  work_t   q_wdata, q_rdata;
  q_stat_t q_stat;
  result_t result;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  lsf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     ({blue_in_i, green_in_i, red_in_i}),
    .q_stat_i    (q_stat),
    .full_o      (full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  lsf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .stat_o (q_stat)
  );

  lsf_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_data_i (q_rdata),
    .q_stat_i (q_stat),
    .q_pop_o  (q_pop),
    .pop_i    (pop),
    .empty_o  (empty),
    .result_o (result)
  );

  assign red_out_o   = result.rgb[0];
  assign green_out_o = result.rgb[1];
  assign blue_out_o  = result.rgb[2];
  assign out_col_o   = result.col;
  assign out_row_o   = result.row;
  assign frame_end_o = result.frame_end;

endmodule
